>>> rtl/core/u8u16_pkg.sv
// ============================================================================
// u8u16_pkg: shared types and decode helpers
// Constants, the run and unit-set structs, and the per-character decode
// function used by the UTF-8 to UTF-16 decoder.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package u8u16_pkg;

   localparam logic [15:0] REPL_CHAR    = 16'hFFFD;
   localparam logic [15:0] HI_SURR_BASE = 16'hD800;
   localparam logic [15:0] LO_SURR_BASE = 16'hDC00;
   localparam logic [20:0] SUPP_BASE    = 21'h10000;

   // One complete run of bytes to decode: it ends with the word that closes a sequence or ends the string.
   typedef struct packed {
      logic            valid;
      logic [3:0][7:0] bytes;
      logic [2:0]      len;
   } run_type;

   // Up to three code units produced by one run.
   typedef struct packed {
      logic [2:0][15:0] units;
      logic [1:0]       count;
   } unit_set_type;

   // One decoded code point and the number of bytes it used.
   typedef struct packed {
      logic [20:0] cp;
      logic [2:0]  used;
   } point_type;

   // Number of following bytes announced by a lead byte (zero if not a lead).
   function automatic logic [1:0] lead_followers(input logic [7:0] c);
      logic [1:0] f;
      f = 2'd0;
      if (c[7:5] == 3'b110) f = 2'd1;
      else if (c[7:4] == 4'b1110) f = 2'd2;
      else if (c[7:3] == 5'b11110) f = 2'd3;
      return f;
   endfunction

   // Decode the character that starts at b[0], with avail bytes left in the run.
   function automatic point_type decode_one(input logic [3:0][7:0] b,
                                            input logic [2:0]      avail);
      point_type  p;
      logic [1:0] f;
      f      = lead_followers(b[0]);
      p.cp   = {5'd0, REPL_CHAR};
      p.used = 3'd1;
      if (!b[0][7]) begin
         p.cp = {13'd0, b[0]};
      end else if ((f != 2'd0) && ({1'b0, f} < avail)) begin
         p.used = {1'b0, f} + 3'd1;
         case (f)
            2'd1: begin
               p.cp = {10'd0, b[0][4:0], b[1][5:0]};
            end
            2'd2: begin
               p.cp = {5'd0, b[0][3:0], b[1][5:0], b[2][5:0]};
            end
            2'd3: begin
               p.cp = {b[0][2:0], b[1][5:0], b[2][5:0], b[3][5:0]};
            end
            default: begin
               p.cp   = {5'd0, REPL_CHAR};
               p.used = 3'd1;
            end
         endcase
      end
      return p;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/u8u16_assembler.sv
// ============================================================================
// u8u16_assembler: sequence collector
// Holds the open UTF-8 sequence and registers a complete run of bytes once
// the current word closes it or the string ends.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module u8u16_assembler (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire logic [7:0]       in_byte,
   input  wire logic             string_end,
   input  wire logic             run_take,
   output u8u16_pkg::run_type    run
);

   logic [2:0][7:0] held_ff, held_in;
   logic [1:0]      cnt_ff, cnt_in;
   logic [1:0]      need_ff, need_in;
   logic            run_vld_ff, run_vld_in;
   logic [3:0][7:0] run_bytes_ff, run_bytes_in;
   logic [2:0]      run_len_ff, run_len_in;
   logic [1:0]      lead_f;
   logic            close_run;

   assign lead_f = u8u16_pkg::lead_followers(in_byte);

   always_comb begin
      held_in      = held_ff;
      cnt_in       = cnt_ff;
      need_in      = need_ff;
      run_bytes_in = run_bytes_ff;
      run_len_in   = run_len_ff;
      close_run    = 1'b0;
      if (accept) begin
         if (cnt_ff == 2'd0) begin
            if ((lead_f != 2'd0) && !string_end) begin
               held_in[0] = in_byte;
               cnt_in     = 2'd1;
               need_in    = lead_f;
            end else begin
               close_run = 1'b1;
            end
         end else if ((need_ff > 2'd1) && !string_end) begin
            held_in[cnt_ff] = in_byte;
            cnt_in          = cnt_ff + 2'd1;
            need_in         = need_ff - 2'd1;
         end else begin
            close_run = 1'b1;
         end
         if (close_run) begin
            // Held bytes first, then the current word right behind them.
            run_bytes_in[0] = (cnt_ff > 2'd0) ? held_ff[0] : in_byte;
            run_bytes_in[1] = (cnt_ff > 2'd1) ? held_ff[1] : in_byte;
            run_bytes_in[2] = (cnt_ff > 2'd2) ? held_ff[2] : in_byte;
            run_bytes_in[3] = in_byte;
            run_len_in      = {1'b0, cnt_ff} + 3'd1;
            cnt_in          = 2'd0;
            need_in         = 2'd0;
         end
      end
      run_vld_in = close_run || (run_vld_ff && !run_take);
   end

   always_ff @(posedge clock) begin
      held_ff      <= held_in;
      run_bytes_ff <= run_bytes_in;
      run_len_ff   <= run_len_in;
      if (reset) begin
         cnt_ff     <= 2'd0;
         need_ff    <= 2'd0;
         run_vld_ff <= 1'b0;
      end else begin
         cnt_ff     <= cnt_in;
         need_ff    <= need_in;
         run_vld_ff <= run_vld_in;
      end
   end

   assign run.valid = run_vld_ff;
   assign run.bytes = run_bytes_ff;
   assign run.len   = run_len_ff;

endmodule

`default_nettype wire

>>> rtl/core/u8u16_decoder.sv
// ============================================================================
// u8u16_decoder: run decoder
// Decodes a complete run of up to four bytes into one to three UTF-16
// code units, splitting supplementary code points into surrogate pairs.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module u8u16_decoder (
   input  wire u8u16_pkg::run_type      run,
   output u8u16_pkg::unit_set_type      unit_set
);

   u8u16_pkg::point_type p0, p1, p2;
   logic [3:0][7:0]      b1, b2;
   logic [2:0]           avail1, avail2;
   logic                 has1, has2;
   logic [20:0]          supp_off;

   always_comb begin
      p0     = u8u16_pkg::decode_one(run.bytes, run.len);
      has1   = p0.used < run.len;
      b1     = run.bytes >> {p0.used, 3'b000};
      avail1 = run.len - p0.used;
      p1     = u8u16_pkg::decode_one(b1, avail1);
      has2   = has1 && (p1.used < avail1);
      b2     = b1 >> {p1.used, 3'b000};
      avail2 = avail1 - p1.used;
      p2     = u8u16_pkg::decode_one(b2, avail2);

      supp_off = p0.cp - u8u16_pkg::SUPP_BASE;

      if (|p0.cp[20:16]) begin
         // A supplementary code point always uses the whole run.
         unit_set.units[0] = u8u16_pkg::HI_SURR_BASE + {5'd0, supp_off[20:10]};
         unit_set.units[1] = u8u16_pkg::LO_SURR_BASE + {6'd0, supp_off[9:0]};
         unit_set.units[2] = u8u16_pkg::REPL_CHAR;
         unit_set.count    = 2'd2;
      end else begin
         unit_set.units[0] = p0.cp[15:0];
         unit_set.units[1] = p1.cp[15:0];
         unit_set.units[2] = p2.cp[15:0];
         unit_set.count    = 2'd1 + {1'b0, has1} + {1'b0, has2};
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/u8u16_unit_queue.sv
// ============================================================================
// u8u16_unit_queue: result register
// Holds the code units of one run and hands them out one unit per cycle
// while rsp_ready is high, flagging the last unit of the run.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module u8u16_unit_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    load,
   input  wire u8u16_pkg::unit_set_type unit_set,
   output logic                         can_load,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [15:0]                  rsp_code_unit,
   output logic                         rsp_run_last
);

   logic [2:0][15:0] units_ff, units_in;
   logic [1:0]       rem_ff, rem_in;
   logic             take;

   assign take     = rsp_valid && rsp_ready;
   assign can_load = (rem_ff == 2'd0) || ((rem_ff == 2'd1) && rsp_ready);

   always_comb begin
      units_in = units_ff;
      rem_in   = rem_ff;
      if (load) begin
         units_in = unit_set.units;
         rem_in   = unit_set.count;
      end else if (take) begin
         units_in[0] = units_ff[1];
         units_in[1] = units_ff[2];
         rem_in      = rem_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      units_ff <= units_in;
      if (reset) begin
         rem_ff <= 2'd0;
      end else begin
         rem_ff <= rem_in;
      end
   end

   assign rsp_valid     = rem_ff != 2'd0;
   assign rsp_code_unit = units_ff[0];
   assign rsp_run_last  = rem_ff == 2'd1;

endmodule

`default_nettype wire

>>> rtl/core/utf8_to_utf16_decoder.sv
// ============================================================================
// utf8_to_utf16_decoder: UTF-8 to UTF-16 stream decoder
// The word that closes a sequence is registered in the run register, then
// decoded and loaded into the result register, which shows its first unit.
// Throughput: one word per cycle while the response side keeps up; a word
// that yields two or three units holds the input while the result register
// drains, one unit per cycle. Reset clears the open sequence and all results.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_utf16_decoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic        req_string_end,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_code_unit,
   output logic             rsp_run_last
);

   // The design is three parts in a row. The assembler collects the lead
   // byte and following bytes of an open sequence and, on the word that
   // closes it (or on the end of the string), registers the whole run. The
   // decoder turns that registered run into one to three code units in a
   // single combinational pass. The unit queue is the result register; it
   // loads a new unit set whenever it is empty or its last unit is being
   // taken, so runs of single units stream at full rate.

   u8u16_pkg::run_type      run;
   u8u16_pkg::unit_set_type unit_set;
   logic                    accept;
   logic                    can_load;
   logic                    run_take;

   // A registered run moves into the result register as soon as it drains.
   assign run_take  = run.valid && can_load;

   // The run register is free, or frees up this cycle.
   assign req_ready = !run.valid || run_take;
   assign accept    = req_valid && req_ready;

   u8u16_assembler u_assembler (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .in_byte    (req_in_byte),
      .string_end (req_string_end),
      .run_take   (run_take),
      .run        (run)
   );

   u8u16_decoder u_decoder (
      .run      (run),
      .unit_set (unit_set)
   );

   u8u16_unit_queue u_unit_queue (
      .clock         (clock),
      .reset         (reset),
      .load          (run_take),
      .unit_set      (unit_set),
      .can_load      (can_load),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_code_unit (rsp_code_unit),
      .rsp_run_last  (rsp_run_last)
   );

   // A registered run always holds between one and four bytes.
   a_run_len: assert property (@(posedge clock) disable iff (reset)
      run.valid |-> (run.len != 3'd0) && (run.len <= 3'd4))
      else $error("run length out of range");

   // Every run yields at least one code unit.
   a_unit_count: assert property (@(posedge clock) disable iff (reset)
      run.valid |-> (unit_set.count != 2'd0))
      else $error("run decoded to no code units");

   // A run waiting on a busy result register keeps its bytes.
   a_run_hold: assert property (@(posedge clock) disable iff (reset)
      (run.valid && !run_take) |=> (run.valid && $stable(run.bytes)))
      else $error("waiting run lost or changed");

   // Units of one run follow one another without a gap in valid.
   a_run_cont: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_run_last) |=> rsp_valid)
      else $error("result run broken before its last unit");

endmodule

`default_nettype wire

>>> test/tb.sv
// ============================================================================
// tb: self-checking bench for the UTF-8 to UTF-16 stream decoder
// Feeds UTF-8 words through the request channel and checks every code unit
// on the response channel against a transcoder model kept in the bench. A
// short directed table comes first, then random text that is mostly well
// formed, with random idling on the request side and random stalls on the
// response side.
// ============================================================================
`timescale 1ns / 1ps

module tb;

   // Code points and surrogate bases, spelled out locally so that the
   // prediction does not lean on the design's own package.
   localparam logic [15:0] REPLACEMENT = 16'hFFFD;
   localparam logic [15:0] HIGH_SURR   = 16'hD800;
   localparam logic [15:0] LOW_SURR    = 16'hDC00;
   localparam logic [20:0] PLANE1_BASE = 21'h10000;

   // Wait after the last phase, long enough to catch anything that trails
   // the last expected unit.
   localparam int DRAIN_CYCLES = 12;
   localparam int RANDOM_PHASE_WORDS = 102;

   // One expected code unit with its end-of-word marker.
   typedef struct packed {
      logic [15:0] code_unit;
      logic        run_last;
   } unit_word_type;

   // One row of the directed table. When typed is set, the row carries its
   // own expectation: either nothing, or a single unit that closes the word.
   typedef struct packed {
      logic [7:0]  data;
      logic        eos;
      logic        typed;
      logic        has_unit;
      logic [15:0] code_unit;
   } stim_row_type;

   // Kinds of character that the random text generator can emit.
   typedef enum int {
      CH_ASCII,
      CH_TWO,
      CH_THREE,
      CH_FOUR,
      CH_NOISE,
      CH_CUT
   } char_kind_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_in_byte;
   logic        req_string_end;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [15:0] rsp_code_unit;
   logic        rsp_run_last;

   // Model state: the bytes of the open sequence and how many are still due.
   logic [7:0]  seq_bytes [3];
   int          seq_count;
   int          seq_missing;

   unit_word_type step_units [$];     // units produced by the word just accepted
   unit_word_type pending_units [$];  // units sent into the block, not yet seen

   int          errors;
   int          words_sent;
   bit          sender_idles;
   bit          receiver_stalls;

   // Directed table. Rows holding part of a sequence produce nothing; the
   // rows that complete a sequence are left to the model.
   stim_row_type directed_rows [22] = '{
      // Zero byte is an ordinary character and does not end the string.
      '{8'h00, 1'b0, 1'b1, 1'b1, 16'h0000},
      '{8'h7F, 1'b0, 1'b1, 1'b1, 16'h007F},
      // A stray continuation byte and a byte that is never a lead.
      '{8'h80, 1'b0, 1'b1, 1'b1, REPLACEMENT},
      '{8'hFF, 1'b0, 1'b1, 1'b1, REPLACEMENT},
      // A valid lead that is itself the last byte of the string.
      '{8'hC2, 1'b1, 1'b1, 1'b1, REPLACEMENT},
      // Overlong two-byte form whose follower has its top bits set.
      '{8'hC0, 1'b0, 1'b1, 1'b0, 16'h0000},
      '{8'hFF, 1'b0, 1'b0, 1'b0, 16'h0000},
      // Three-byte character.
      '{8'hE2, 1'b0, 1'b1, 1'b0, 16'h0000},
      '{8'h82, 1'b0, 1'b1, 1'b0, 16'h0000},
      '{8'hAC, 1'b0, 1'b0, 1'b0, 16'h0000},
      // Largest value a four-byte lead can carry, split into a pair.
      '{8'hF7, 1'b0, 1'b1, 1'b0, 16'h0000},
      '{8'hBF, 1'b0, 1'b1, 1'b0, 16'h0000},
      '{8'hBF, 1'b0, 1'b1, 1'b0, 16'h0000},
      '{8'hBF, 1'b0, 1'b0, 1'b0, 16'h0000},
      // Surrogate code point encoded directly passes through unchecked.
      '{8'hED, 1'b0, 1'b1, 1'b0, 16'h0000},
      '{8'hA0, 1'b0, 1'b1, 1'b0, 16'h0000},
      '{8'h80, 1'b0, 1'b0, 1'b0, 16'h0000},
      // String ends inside a sequence: the held bytes are decoded again.
      '{8'hE2, 1'b0, 1'b1, 1'b0, 16'h0000},
      '{8'h41, 1'b1, 1'b0, 1'b0, 16'h0000},
      // Truncated sequence that yields three replacement units.
      '{8'hF0, 1'b0, 1'b1, 1'b0, 16'h0000},
      '{8'hF0, 1'b0, 1'b1, 1'b0, 16'h0000},
      '{8'hFF, 1'b1, 1'b0, 1'b0, 16'h0000}
   };

   utf8_to_utf16_decoder u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_byte    (req_in_byte),
      .req_string_end (req_string_end),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_code_unit  (rsp_code_unit),
      .rsp_run_last   (rsp_run_last)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Number of following bytes that a lead byte announces; zero otherwise.
   function automatic int lead_tail_len(input logic [7:0] c);
      if ((c & 8'hE0) == 8'hC0) return 1;
      if ((c & 8'hF0) == 8'hE0) return 2;
      if ((c & 8'hF8) == 8'hF0) return 3;
      return 0;
   endfunction

   // At most three units can come out of a single word.
   function automatic void add_unit(input logic [15:0] u);
      if (step_units.size() < 3) step_units.push_back('{u, 1'b0});
   endfunction

   // Emits a code point, as a surrogate pair when it lies above the BMP.
   function automatic void put_point(input logic [20:0] cp);
      logic [20:0] v;
      if (cp > 21'h00FFFF) begin
         v = cp - PLANE1_BASE;
         add_unit(HIGH_SURR + {5'd0, v[20:10]});
         add_unit(LOW_SURR + {6'd0, v[9:0]});
      end else begin
         add_unit(cp[15:0]);
      end
   endfunction

   // Advances the model by one accepted word and leaves the code units that
   // the word completes in step_units.
   function automatic void transcode_byte(input logic [7:0] b, input logic eos);
      logic [7:0]    run [4];
      logic [20:0]   cp;
      unit_word_type tail_unit;
      int            len;
      int            pos;
      int            tail;
      int            i;
      int            j;
      step_units.delete();
      if (seq_count == 0) begin
         tail = lead_tail_len(b);
         // A lead opens a sequence unless the string ends right here.
         if (tail != 0 && !eos) begin
            seq_bytes[0] = b;
            seq_count    = 1;
            seq_missing  = tail;
            return;
         end
      end else if (seq_missing > 1 && !eos) begin
         seq_bytes[seq_count] = b;
         seq_count++;
         seq_missing--;
         return;
      end
      // The run is complete, or the string ended early: decode it as a
      // finite string, where a lead without all its followers is replaced.
      for (i = 0; i < seq_count; i++) run[i] = seq_bytes[i];
      run[seq_count] = b;
      len = seq_count + 1;
      pos = 0;
      while (pos < len) begin
         tail = lead_tail_len(run[pos]);
         if (!run[pos][7]) begin
            cp = {13'd0, run[pos]};
            pos++;
         end else if (tail != 0 && pos + tail < len) begin
            cp = {13'd0, run[pos] & (8'h3F >> tail)};
            for (j = 1; j <= tail; j++) cp = {cp[14:0], run[pos + j][5:0]};
            pos += tail + 1;
         end else begin
            cp = {5'd0, REPLACEMENT};
            pos++;
         end
         put_point(cp);
      end
      seq_count   = 0;
      seq_missing = 0;
      if (step_units.size() != 0) begin
         tail_unit          = step_units.pop_back();
         tail_unit.run_last = 1'b1;
         step_units.push_back(tail_unit);
      end
   endfunction

   // Presents one word, waits for it to be taken and records what the block
   // owes for it. Typed rows substitute their own expectation.
   task automatic send_word(input logic [7:0] b, input logic eos, input logic typed,
                            input logic has_unit, input logic [15:0] typed_unit);
      int gap;
      gap = sender_idles ? $urandom_range(0, 9) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_in_byte    <= b;
      req_string_end <= eos;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      transcode_byte(b, eos);
      if (typed) begin
         step_units.delete();
         if (has_unit) step_units.push_back('{typed_unit, 1'b1});
      end
      foreach (step_units[k]) pending_units.push_back(step_units[k]);
      words_sent++;
   endtask

   // Drops valid and waits until every owed unit has come back.
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      while (pending_units.size() != 0) @(posedge clock);
   endtask

   // Sends one random string. Most characters are well formed with random
   // content; a few are noise bytes or sequences cut short. The string end
   // flag rides on the last word, so a cut character at the end exercises
   // the early-end path.
   task automatic send_random_text();
      logic [7:0]    text [$];
      logic [31:0]   r;
      char_kind_type kind;
      int            n_chars;
      int            pick;
      int            tail;
      int            keep;
      int            c;
      int            i;
      n_chars = $urandom_range(1, 5);
      for (c = 0; c < n_chars; c++) begin
         pick = $urandom_range(0, 15);
         kind = (pick < 5)  ? CH_ASCII :
                (pick < 8)  ? CH_TWO   :
                (pick < 11) ? CH_THREE :
                (pick < 14) ? CH_FOUR  :
                (pick == 14) ? CH_NOISE : CH_CUT;
         r = $urandom;
         if (kind == CH_ASCII) begin
            text.push_back({1'b0, r[6:0]});
         end else if (kind == CH_NOISE) begin
            text.push_back(r[7:0]);
         end else begin
            tail = (kind == CH_TWO)   ? 1 :
                   (kind == CH_THREE) ? 2 :
                   (kind == CH_FOUR)  ? 3 : $urandom_range(1, 3);
            keep = (kind == CH_CUT) ? $urandom_range(0, tail - 1) : tail;
            case (tail)
               1: begin
                  text.push_back({3'b110, r[4:0]});
               end
               2: begin
                  text.push_back({4'b1110, r[3:0]});
               end
               default: begin
                  text.push_back({5'b11110, r[2:0]});
               end
            endcase
            // Followers are normally 10xxxxxx, but the top bits are never
            // checked, so now and then a fully random byte follows.
            repeat (keep) begin
               r = $urandom;
               if ($urandom_range(0, 7) == 0) text.push_back(r[7:0]);
               else text.push_back({2'b10, r[5:0]});
            end
         end
      end
      for (i = 0; i < text.size(); i++) begin
         send_word(text[i], i == text.size() - 1, 1'b0, 1'b0, 16'h0000);
      end
   endtask

   // One stretch of random text under a fixed idling mode, ending with a
   // full drain so that the sender has to wait on the receiver.
   task automatic random_phase(input bit idle_req, input bit stall_rsp);
      int target;
      sender_idles    = idle_req;
      receiver_stalls = stall_rsp;
      target          = words_sent + RANDOM_PHASE_WORDS;
      while (words_sent < target) send_random_text();
      hold_until_drained();
   endtask

   // Response side: before each unit the receiver holds ready low for a
   // random number of cycles, or not at all when stalls are switched off.
   // Ready is only lowered when a gap is drawn, so it never gets two
   // assignments in the same time step.
   initial begin
      int gap;
      rsp_ready = 1'b0;
      forever begin
         gap = receiver_stalls ? $urandom_range(0, 9) : 0;
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // Scoreboard: every unit taken from the block is matched against the
   // oldest unit still owed.
   always @(posedge clock) begin
      unit_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_units.size() == 0) begin
            $error("unexpected code unit %h (run_last %b)", rsp_code_unit, rsp_run_last);
            errors++;
         end else begin
            want = pending_units.pop_front();
            if (rsp_code_unit !== want.code_unit) begin
               $error("code_unit: expected %h, got %h", want.code_unit, rsp_code_unit);
               errors++;
            end
            if (rsp_run_last !== want.run_last) begin
               $error("run_last: expected %b, got %b", want.run_last, rsp_run_last);
               errors++;
            end
         end
      end
   end

   // Main sequence: reset, the directed table, four random phases that walk
   // through every combination of request idling and response stalls, then
   // a drain and the verdict.
   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_in_byte     = 8'h00;
      req_string_end  = 1'b0;
      errors          = 0;
      words_sent      = 0;
      seq_count       = 0;
      seq_missing     = 0;
      sender_idles    = 1'b1;
      receiver_stalls = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         send_word(directed_rows[r].data, directed_rows[r].eos, directed_rows[r].typed,
                   directed_rows[r].has_unit, directed_rows[r].code_unit);
      end
      hold_until_drained();

      random_phase(1'b1, 1'b1);
      random_phase(1'b0, 1'b0);
      random_phase(1'b1, 1'b0);
      random_phase(1'b0, 1'b1);

      // Give any stray unit time to surface before calling the result.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && pending_units.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Watchdog: the slowest correct run is far below 5 ms of simulated time.
   initial begin
      #5000000;
      $display("simulation failed");
      $finish;
   end

endmodule
